>>> rtl/flow_keyed_emit_rate_limiter_assert.svh
// assertion macros for the flow rate limiter
`ifndef FLOW_KEYED_EMIT_RATE_LIMITER_ASSERT_SVH
`define FLOW_KEYED_EMIT_RATE_LIMITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define FKERL_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define FKERL_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FKERL_ASSERT(name, clk, rst_n, prop, msg)
`define FKERL_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> rtl/fkerl_pkg.sv
`default_nettype none

package fkerl_pkg;

  localparam int ADDR_W     = 64;
  localparam int PORTS_W    = 32;
  localparam int STAMP_W    = 64;
  localparam int WIN_W      = 32;
  localparam int LIMIT_W    = 7;
  localparam int IN_TDATA_W = 160;
  localparam int OUT_TDATA_W = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // item kinds carried in tuser
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // register select, paddr bit 2
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [WIN_W-1:0]   WINDOW_RESET = 32'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd64;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addresses;
    logic [PORTS_W-1:0] ports;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic sweep;
    logic clr_step;
    logic evict;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic fresh;
    logic scan_end;
    logic clr_last;
    logic full;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/fkerl_ram.sv
`default_nettype none

module fkerl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/fkerl_dp.sv
`default_nettype none

module fkerl_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fkerl_pkg::cmd_t                   cmd_i,
  output fkerl_pkg::sts_t                   sts_o,
  input  logic [31:0]                       src_ip_i,
  input  logic [31:0]                       dst_ip_i,
  input  logic [15:0]                       src_port_i,
  input  logic [15:0]                       dst_port_i,
  input  logic [fkerl_pkg::STAMP_W-1:0]     now_ms_i,
  input  logic [fkerl_pkg::WIN_W-1:0]       window_ms_i,
  input  logic [fkerl_pkg::LIMIT_W-1:0]     entry_limit_i
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int LIM_W = (CNT_W > fkerl_pkg::LIMIT_W) ? CNT_W : fkerl_pkg::LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(TABLE_ENTRIES);

  // item key and time
  logic [fkerl_pkg::ADDR_W-1:0]  addr_q;
  logic [fkerl_pkg::PORTS_W-1:0] ports_q;
  logic [fkerl_pkg::STAMP_W-1:0] now_q;

  // scan pipeline and trackers
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             issue_done_q, issue_done_d;
  logic             cmp_valid_q, cmp_valid_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             live_found_q, live_found_d;
  logic [IDX_W-1:0] live_idx_q, live_idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  fkerl_pkg::entry_t ram_wdata;
  logic              ram_re;
  fkerl_pkg::entry_t ram_rdata;
  fkerl_pkg::entry_t new_entry;

  logic                          issuing;
  logic [fkerl_pkg::STAMP_W-1:0] elapsed;
  logic                          fresh;
  logic                          hit;
  logic                          free_cond;
  logic                          sweep_drop;
  logic                          clr_last;
  logic [LIM_W-1:0]              lim_raw;
  logic [LIM_W-1:0]              lim_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= {src_ip_i, dst_ip_i};
      ports_q <= {src_port_i, dst_port_i};
      now_q   <= now_ms_i;
    end
  end

  assign issuing   = cmd_i.scan_step & ~issue_done_q;
  assign ram_re    = issuing;
  assign elapsed   = now_q - ram_rdata.stamp;
  assign fresh     = elapsed < {{(fkerl_pkg::STAMP_W - fkerl_pkg::WIN_W){1'b0}}, window_ms_i};
  assign hit       = cmp_valid_q & ram_rdata.valid & (ram_rdata.addresses == addr_q)
                   & (ram_rdata.ports == ports_q);
  // in the expiry sweep an expired entry counts as free
  assign free_cond = ~ram_rdata.valid | (cmd_i.sweep & ~fresh);
  assign sweep_drop = cmd_i.scan_step & cmd_i.sweep & cmp_valid_q & ram_rdata.valid & ~fresh;
  assign clr_last  = (rd_idx_q == LAST_IDX);

  assign new_entry = '{valid: 1'b1, addresses: addr_q, ports: ports_q, stamp: now_q};

  // single write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_wdata = '0;
    priority if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.scan_step & ~cmd_i.sweep & hit & ~fresh) begin
      ram_we    = 1'b1;
      ram_waddr = cmp_idx_q;
      ram_wdata = new_entry;
    end else if (sweep_drop) begin
      ram_we    = 1'b1;
      ram_waddr = cmp_idx_q;
    end else if (cmd_i.evict) begin
      ram_we    = 1'b1;
      ram_waddr = live_idx_q;
    end else if (cmd_i.insert) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx_q;
      ram_wdata = new_entry;
    end else begin
      ram_we = 1'b0;
    end
  end

  // entry limit clamped to one .. table size
  always_comb begin
    lim_raw = LIM_W'(entry_limit_i);
    priority if (lim_raw == '0) begin
      lim_eff = LIM_W'(1);
    end else if (lim_raw > MAX_LIM) begin
      lim_eff = MAX_LIM;
    end else begin
      lim_eff = lim_raw;
    end
  end

  always_comb begin
    rd_idx_d     = rd_idx_q;
    issue_done_d = issue_done_q;
    cmp_valid_d  = issuing;
    cmp_idx_d    = rd_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    live_found_d = live_found_q;
    live_idx_d   = live_idx_q;
    cnt_d        = cnt_q;

    if (cmd_i.scan_init) begin
      rd_idx_d     = '0;
      issue_done_d = 1'b0;
      cmp_valid_d  = 1'b0;
      free_found_d = 1'b0;
      live_found_d = 1'b0;
    end else begin
      if (cmd_i.clr_step || issuing) begin
        rd_idx_d = clr_last ? '0 : rd_idx_q + IDX_W'(1);
      end
      if (issuing && clr_last) begin
        issue_done_d = 1'b1;
      end
      if (cmd_i.scan_step && cmp_valid_q) begin
        if (!free_found_q && free_cond) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
        if (cmd_i.sweep && !live_found_q && ram_rdata.valid && fresh) begin
          live_found_d = 1'b1;
          live_idx_d   = cmp_idx_q;
        end
      end
      // evicted slot may be lower than any free one
      if (cmd_i.evict && (!free_found_q || live_idx_q < free_idx_q)) begin
        free_found_d = 1'b1;
        free_idx_d   = live_idx_q;
      end
    end

    priority if (cmd_i.clr_step && clr_last) begin
      cnt_d = '0;
    end else if (sweep_drop || cmd_i.evict) begin
      cnt_d = cnt_q - CNT_W'(1);
    end else if (cmd_i.insert) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      cmp_valid_q  <= 1'b0;
      cmp_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      live_found_q <= 1'b0;
      live_idx_q   <= '0;
      cnt_q        <= '0;
    end else begin
      rd_idx_q     <= rd_idx_d;
      issue_done_q <= issue_done_d;
      cmp_valid_q  <= cmp_valid_d;
      cmp_idx_q    <= cmp_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      live_found_q <= live_found_d;
      live_idx_q   <= live_idx_d;
      cnt_q        <= cnt_d;
    end
  end

  fkerl_ram #(
    .WIDTH ($bits(fkerl_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign sts_o.hit      = hit;
  assign sts_o.fresh    = fresh;
  assign sts_o.scan_end = cmp_valid_q & (cmp_idx_q == LAST_IDX);
  assign sts_o.clr_last = clr_last;
  assign sts_o.full     = LIM_W'(cnt_q) >= lim_eff;

endmodule

`default_nettype wire

>>> rtl/fkerl_ctrl.sv
`default_nettype none

module fkerl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_cmd_i,
  output logic            out_valid_o,
  output logic            out_emit_o,
  input  logic            out_ready_i,
  output fkerl_pkg::cmd_t cmd_o,
  input  fkerl_pkg::sts_t sts_i
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_CLEAR  = 9'b000000100,
    ST_LOOK   = 9'b000001000,
    ST_SWEEP  = 9'b000010000,
    ST_CHECK  = 9'b000100000,
    ST_EVICT  = 9'b001000000,
    ST_INSERT = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;
  logic   out_valid_q, out_valid_d;
  logic   out_emit_q, out_emit_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d     = state_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_emit_d  = out_emit_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan_init = 1'b1;
          if (in_cmd_i == fkerl_pkg::CMD_CLEAR) begin
            emit_d  = 1'b0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_DONE;
      end
      ST_LOOK: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          emit_d  = ~sts_i.fresh;
          state_d = ST_DONE;
        end else if (sts_i.scan_end) begin
          if (sts_i.full) begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SWEEP;
          end else begin
            state_d = ST_INSERT;
          end
        end
      end
      ST_SWEEP: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.sweep     = 1'b1;
        if (sts_i.scan_end) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.full ? ST_EVICT : ST_INSERT;
      end
      ST_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        emit_d       = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_emit_d  = emit_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_q     <= emit_d;
    out_emit_q <= out_emit_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_emit_o  = out_emit_q;

endmodule

`default_nettype wire

>>> rtl/flow_keyed_emit_rate_limiter.sv
// channel    dir  handshake                     payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata: src_ip, dst_ip, src_port,
//                                               dst_port, now_ms; tuser: cmd
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata: emit
// apb        in   psel/penable/pwrite/pready    window_ms at 0x0, entry_limit at 0x4
//
// one item at a time; each table scan reads one slot per cycle from the table ram
// a miss on a full table adds an expiry sweep, and an eviction if the table is still full
// after reset a clearing pass over the table runs before the first transfer
// a waiting result sits in the output register; the next item is taken meanwhile
`default_nettype none
`include "flow_keyed_emit_rate_limiter_assert.svh"

module flow_keyed_emit_rate_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] src_ip, [63:32] dst_ip, [79:64] src_port, [95:80] dst_port, [159:96] now_ms
  input  logic [fkerl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] emit, [7:1] zero
  output logic [fkerl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fkerl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fkerl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fkerl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  // configuration registers
  logic [fkerl_pkg::WIN_W-1:0]   window_q, window_d;
  logic [fkerl_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic                          cfg_we;

  fkerl_pkg::cmd_t cmd;
  fkerl_pkg::sts_t sts;
  logic            emit;
  logic [3:0]      wr_cmds;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  // word select on paddr bit 2, byte lanes ignored
  always_comb begin
    window_d = window_q;
    limit_d  = limit_q;
    if (cfg_we) begin
      unique case (paddr[2])
        fkerl_pkg::REG_WINDOW: window_d = pwdata;
        fkerl_pkg::REG_LIMIT:  limit_d  = pwdata[fkerl_pkg::LIMIT_W-1:0];
        default:               window_d = window_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fkerl_pkg::REG_WINDOW: prdata = window_q;
      fkerl_pkg::REG_LIMIT:
        prdata = {{(fkerl_pkg::APB_DATA_W - fkerl_pkg::LIMIT_W){1'b0}}, limit_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= fkerl_pkg::WINDOW_RESET;
      limit_q  <= fkerl_pkg::LIMIT_RESET;
    end else begin
      window_q <= window_d;
      limit_q  <= limit_d;
    end
  end

  // sequencer: lookup, expiry sweep, eviction, insert, clear
  fkerl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_emit_o  (emit),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // flow table, scan pointers, slot count
  fkerl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .src_ip_i      (s_axis_tdata[31:0]),
    .dst_ip_i      (s_axis_tdata[63:32]),
    .src_port_i    (s_axis_tdata[79:64]),
    .dst_port_i    (s_axis_tdata[95:80]),
    .now_ms_i      (s_axis_tdata[159:96]),
    .window_ms_i   (window_q),
    .entry_limit_i (limit_q)
  );

  assign m_axis_tdata = {{(fkerl_pkg::OUT_TDATA_W - 1){1'b0}}, emit};

  // commands that drive the single table write port
  assign wr_cmds = {cmd.clr_step, cmd.scan_step, cmd.evict, cmd.insert};

  `FKERL_ASSERT(a_one_writer, clk_i, rst_ni, $onehot0(wr_cmds), "table write commands overlap")
  `FKERL_ASSERT(a_busy_after_transfer, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while an item is in work")
  `FKERL_ASSERT_ALWAYS(a_init_pass, clk_i, !rst_ni |=> !s_axis_tready, "input ready before the clearing pass")

endmodule

`default_nettype wire

>>> bench/flow_rate_checker.sv
module flow_rate_checker #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [fkerl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [0:0]                          s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [fkerl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fkerl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fkerl_pkg::APB_DATA_W-1:0]    pwdata,
  input  logic [fkerl_pkg::APB_DATA_W-1:0]    prdata,
  input  logic                                pready,
  output int                                  errors_o,
  output int                                  pending_o
);
  import fkerl_pkg::*;

  // one check transfer as laid out on tdata, lowest field last
  typedef struct packed {
    logic [STAMP_W-1:0] now_ms;
    logic [15:0]        dst_port;
    logic [15:0]        src_port;
    logic [31:0]        dst_ip;
    logic [31:0]        src_ip;
  } flow_req_t;

  entry_t             flow_table [TABLE_SLOTS];
  int                 slots_used;
  logic [WIN_W-1:0]   window;
  logic [LIMIT_W-1:0] limit;
  logic               emit_q [$];

  initial errors_o = 0;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
    errors_o = errors_o + 1;
  endtask

  // decides emit for one transfer and updates the flow table
  function automatic logic flow_emit_decision(input logic kind, input flow_req_t req);
    logic [ADDR_W-1:0]  key_addr;
    logic [PORTS_W-1:0] key_ports;
    logic [STAMP_W-1:0] win;
    int                 hit;
    int                 lim;
    logic               done;
    if (kind == CMD_CLEAR) begin
      for (int i = 0; i < TABLE_SLOTS; i++) flow_table[i].valid = 1'b0;
      slots_used = 0;
      return 1'b0;
    end
    key_addr  = {req.src_ip, req.dst_ip};
    key_ports = {req.src_port, req.dst_port};
    win       = {32'd0, window};
    hit       = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (hit < 0 && flow_table[i].valid && flow_table[i].addresses == key_addr &&
          flow_table[i].ports == key_ports)
        hit = i;
    end
    if (hit >= 0) begin
      if (req.now_ms - flow_table[hit].stamp < win) return 1'b0;
      flow_table[hit].stamp = req.now_ms;
      return 1'b1;
    end
    lim = (limit == 0) ? 1 : (int'(limit) > TABLE_SLOTS) ? TABLE_SLOTS : int'(limit);
    if (slots_used >= lim) begin
      // expiry sweep, then evict the lowest valid slot if still full
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (flow_table[i].valid && req.now_ms - flow_table[i].stamp >= win) begin
          flow_table[i].valid = 1'b0;
          slots_used--;
        end
      end
      done = 1'b0;
      if (slots_used >= lim) begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!done && flow_table[i].valid) begin
            flow_table[i].valid = 1'b0;
            slots_used--;
            done = 1'b1;
          end
        end
      end
    end
    done = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!done && !flow_table[i].valid) begin
        flow_table[i].valid     = 1'b1;
        flow_table[i].addresses = key_addr;
        flow_table[i].ports     = key_ports;
        flow_table[i].stamp     = req.now_ms;
        slots_used++;
        done = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) flow_table[i].valid = 1'b0;
      slots_used = 0;
      window     = WINDOW_RESET;
      limit      = LIMIT_RESET;
      emit_q.delete();
      pending_o <= 0;
    end else begin
      // results first: a result leaving now belongs to an earlier transfer
      if (m_axis_tvalid && m_axis_tready) begin
        if (emit_q.size() == 0)
          report_mismatch("emit with no transfer waiting", 64'd0, m_axis_tdata);
        else if (m_axis_tdata[0] !== emit_q[0]) begin
          report_mismatch("emit", emit_q[0], m_axis_tdata[0]);
          void'(emit_q.pop_front());
        end else
          void'(emit_q.pop_front());
      end
      if (s_axis_tvalid && s_axis_tready)
        emit_q.push_back(flow_emit_decision(s_axis_tuser[0], flow_req_t'(s_axis_tdata)));
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_LIMIT) limit = pwdata[LIMIT_W-1:0];
          else window = pwdata;
        end else if (paddr[2] == REG_LIMIT) begin
          if (prdata !== {25'd0, limit}) report_mismatch("entry_limit readback", limit, prdata);
        end else if (prdata !== window)
          report_mismatch("window_ms readback", window, prdata);
      end
      pending_o <= emit_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  import fkerl_pkg::*;

  localparam int TABLE_ENTRIES   = 64;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int POOL_MAX        = 72;
  // longest receiver hold-off, counted by the receiver itself
  localparam int HOLD_OFF_CYCLES = 300;
  // slowest item is a miss with a sweep
  localparam int TAIL_CYCLES     = 2 * TABLE_ENTRIES + 16;
  // several times the worst quiet stretch: hold-off plus a sweep
  localparam int WATCHDOG_LIMIT  = 2000;

  // flow key, most significant field first
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } flow_key_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [31:0] src_ip, [63:32] dst_ip, [79:64] src_port, [95:80] dst_port, [159:96] now_ms
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [0] cmd
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [0] emit, [7:1] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int errors;
  int pending;
  int tx_idle_pct;
  int rx_idle_pct;
  int holds_asked;
  int holds_served;
  int quiet_cycles;

  flow_key_t pool [POOL_MAX];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  flow_keyed_emit_rate_limiter #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  flow_rate_checker #(
    .TABLE_SLOTS (TABLE_ENTRIES)
  ) flow_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // offer one transfer, with random idle cycles ahead of it, and wait for it to be taken
  task automatic send_item(input logic kind, input flow_key_t key, input logic [63:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {stamp, key.dst_port, key.src_port, key.dst_ip, key.src_ip};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every emit has come back
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // register write, then read it back so the checker sees prdata
  task automatic program_reg(input logic sel, input logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  initial begin
    m_axis_tready = 1'b0;
    holds_served  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        holds_served++;
      end else
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int              phase;
    int              pick;
    int              pool_size;
    int              eff;
    logic [31:0]     win;
    logic [6:0]      lim;
    logic [63:0]     base;
    logic [63:0]     step_max;
    flow_key_t       key_zero;
    flow_key_t       key_ones;
    flow_key_t       key_a;
    flow_key_t       key_b;
    flow_key_t       noise;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CHECK;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet_cycles  = 0;
    holds_asked   = 0;
    tx_idle_pct   = 16;
    rx_idle_pct   = 56;
    key_zero      = '0;
    key_ones      = '1;
    key_a         = {$urandom, $urandom, $urandom};
    key_b         = {$urandom, $urandom, $urandom};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, window 1000 and limit 64
    send_item(CMD_CLEAR, key_ones, '1);
    send_item(CMD_CHECK, key_ones, '1);
    send_item(CMD_CHECK, key_zero, 64'd0);
    send_item(CMD_CHECK, key_zero, 64'd999);    // one short of the window
    send_item(CMD_CHECK, key_zero, 64'd1000);   // window reached, refresh
    send_item(CMD_CHECK, key_ones, 64'd998);    // age wraps past zero, still young
    drain();

    // limit 2: sweep out an expired flow, then evict the lowest slot
    program_reg(REG_LIMIT, 32'd2);
    send_item(CMD_CHECK, key_a, 64'd1500);      // ones expired, swept
    send_item(CMD_CHECK, key_b, 64'd1600);      // nothing expired, a evicted
    send_item(CMD_CHECK, key_a, 64'd1700);      // a was gone, new again
    send_item(CMD_CHECK, key_zero, 64'd1800);   // still known and young
    send_item(CMD_CLEAR, key_zero, 64'd0);
    send_item(CMD_CHECK, key_zero, 64'd1900);   // new after the clear
    drain();

    // zero window never suppresses; limit zero acts as one
    program_reg(REG_WINDOW, 32'd0);
    program_reg(REG_LIMIT, 32'd0);
    send_item(CMD_CHECK, key_a, 64'd5);
    send_item(CMD_CHECK, key_a, 64'd5);
    send_item(CMD_CHECK, key_b, 64'd5);
    send_item(CMD_CHECK, {$urandom, $urandom, $urandom}, {$urandom, $urandom});
    drain();

    // widest window; limit above the table size
    program_reg(REG_WINDOW, 32'hFFFF_FFFF);
    program_reg(REG_LIMIT, 32'd127);
    send_item(CMD_CHECK, key_a, 64'd0);
    send_item(CMD_CHECK, key_a, 64'h0000_0000_FFFF_FFFE);
    send_item(CMD_CHECK, key_a, 64'h0000_0001_0000_0000);
    send_item(CMD_CLEAR, key_ones, '1);

    // random phases over a range of window and limit settings
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       begin win = 32'd1000;      lim = 7'd64;  end
        1:       begin win = 32'd0;         lim = 7'd1;   end
        2:       begin win = 32'd1;         lim = 7'd0;   end
        3:       begin win = 32'hFFFF_FFFF; lim = 7'd127; end
        4:       begin win = $urandom_range(2, 5000); lim = 7'd8; end
        5:       begin win = 32'd50;        lim = 7'd3;   end
        6:       begin win = 32'd200;       lim = 7'd16;  end
        7:       begin win = 32'd1000;      lim = 7'd2;   end
        default: begin win = $urandom_range(2, 5000); lim = 7'd64; end
      endcase
      program_reg(REG_WINDOW, win);
      program_reg(REG_LIMIT, {25'd0, lim});

      // idle pattern: sender light then heavy, then none at all
      case (phase / 3)
        0:       begin tx_idle_pct = 16; rx_idle_pct = 56; end
        1:       begin tx_idle_pct = 56; rx_idle_pct = 16; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase

      // a pool a few flows bigger than the limit keeps the table at its edge
      eff = (lim == 0) ? 1 : (int'(lim) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(lim);
      pool_size = eff + $urandom_range(1, 4);
      for (int k = 0; k < pool_size; k++) pool[k] = {$urandom, $urandom, $urandom};
      base = {$urandom, $urandom};
      // a pool flow comes back after roughly one window on average
      step_max = ({32'd0, win} * 64'd2) / pool_size + 64'd1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == 40) holds_asked++;
        if (phase == 4 && n == 50) drain();
        base = base + ({$urandom, $urandom} % (step_max + 64'd1));
        pick = $urandom_range(99);
        noise = {$urandom, $urandom, $urandom};
        if (pick < 4)
          send_item(CMD_CLEAR, noise, {$urandom, $urandom});
        else if (pick < 9)
          send_item(CMD_CHECK, noise, base);
        else if (pick < 13)
          send_item(CMD_CHECK, pool[$urandom_range(pool_size - 1)], {$urandom, $urandom});
        else
          send_item(CMD_CHECK, pool[$urandom_range(pool_size - 1)], base);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> flow_keyed_emit_rate_limiter.f
+incdir+rtl
rtl/fkerl_pkg.sv
rtl/fkerl_ram.sv
rtl/fkerl_dp.sv
rtl/fkerl_ctrl.sv
rtl/flow_keyed_emit_rate_limiter.sv
bench/flow_rate_checker.sv
bench/tb_top.sv
